// File: rtl/pfsa_pkg.sv
// shared types, constants and helpers for the page frame stack allocator
package pfsa_pkg;

  // sizing
  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_FRAMES);
  localparam int unsigned FRM_W      = IDX_W + 1;
  localparam int unsigned SPG_W      = FRM_W + 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  // page shift limits
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(6);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(16);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(12);

  // request kinds
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = CFG_IDX_W'(2);

  // shared unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SHR,
    ALU_SHL
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [SHIFT_W-1:0]   sh;
  } alu_ctl_t;

  // stack memory write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } ram_wr_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_TOT,
    ST_I_ADD,
    ST_I_SPG,
    ST_I_SHL,
    ST_I_BASE,
    ST_I_FRM,
    ST_I_FILL,
    ST_A_POP,
    ST_A_SHL,
    ST_A_ADD,
    ST_F_SUB,
    ST_F_SHR,
    ST_RESP
  } state_t;

  // page shift held to its legal range
  function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] r;
    r = s;
    if (s < SHIFT_MIN) r = SHIFT_MIN;
    if (s > SHIFT_MAX) r = SHIFT_MAX;
    return r;
  endfunction

endpackage

// File: rtl/pfsa_ram.sv
// free frame index stack memory, one write and one registered read port
module pfsa_ram (
  input  logic                          clk,
  input  pfsa_pkg::ram_wr_t             wr,
  input  logic                          rd_en,
  input  logic [pfsa_pkg::IDX_W-1:0]    rd_addr,
  output logic [pfsa_pkg::IDX_W-1:0]    rd_data
);

  logic [pfsa_pkg::IDX_W-1:0] mem [pfsa_pkg::MAX_FRAMES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pfsa_alu.sv
// shared add, subtract and shift unit driven by the sequencer
module pfsa_alu (
  input  pfsa_pkg::alu_ctl_t            ctl,
  input  logic [pfsa_pkg::ADDR_W-1:0]   a,
  input  logic [pfsa_pkg::ADDR_W-1:0]   b,
  output logic [pfsa_pkg::ADDR_W-1:0]   res,
  output logic                          borrow
);

  logic [pfsa_pkg::ADDR_W:0] diff;

  // one operation per cycle
  always_comb begin
    diff   = {1'b0, a} - {1'b0, b};
    res    = a;
    borrow = 1'b0;
    case (ctl.op)
      pfsa_pkg::ALU_ADD: res = a + b;
      pfsa_pkg::ALU_SUB: begin
        res    = diff[pfsa_pkg::ADDR_W-1:0];
        borrow = diff[pfsa_pkg::ADDR_W];
      end
      pfsa_pkg::ALU_SHR: res = a >> ctl.sh;
      pfsa_pkg::ALU_SHL: res = a << ctl.sh;
      default: res = a;
    endcase
  end

endmodule

// File: rtl/page_frame_stack_allocator.sv
// top level: request sequencer, allocator state and result register
//
// Page frame allocator keeping free frame indices on a stack memory.
// Input channel (in_*): one transaction per request; in_tuser carries the
// request kind (init, allocate, free), in_tdata the address being freed.
// Result channel (out_*): exactly one transaction per request, carrying
// the allocated frame address and a status code.
// Configuration (cfg_*): region base, region size and page shift must be
// written by the user while no request is in flight; the block does not
// enforce it, and they never start an init. All work uses one shared
// add/subtract/shift unit, one step per cycle: allocate pops, shifts and
// adds; free subtracts and shifts; init sizes the region, then fills one
// stack entry per usable frame. An empty stack or a free below base skips
// the later steps, an unused kind goes straight to the result, and the pop
// waits for the registered read. A new request is taken once the previous
// result sits in the output register, even while the receiver holds off.
// If the receiver stalls with a result already waiting, the sequencer
// holds its finished result and in_tready stays low until the slot frees.
// Reset clears the allocator to no free frames and page shift to 12; the
// stack memory itself is not cleared.
module page_frame_stack_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] free_address
  input  logic [1:0]                        in_tuser,   // [1:0] req_type
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [31:0] frame_address
  output logic [1:0]                        out_tuser,  // [1:0] status
  // configuration write port
  input  logic                              cfg_we,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  localparam int unsigned AW = pfsa_pkg::ADDR_W;
  localparam int unsigned FW = pfsa_pkg::FRM_W;
  localparam int unsigned IW = pfsa_pkg::IDX_W;
  localparam int unsigned SW = pfsa_pkg::SPG_W;
  localparam logic [FW-1:0] MAX_FRM = FW'(pfsa_pkg::MAX_FRAMES);

  pfsa_pkg::state_t                 state_r, state_nxt;
  logic [1:0]                       req_type_r, req_type_nxt;
  logic [AW-1:0]                    free_addr_r, free_addr_nxt;
  logic [AW-1:0]                    region_base_r, region_size_r;
  logic [pfsa_pkg::SHIFT_W-1:0]     page_shift_r;
  logic [FW-1:0]                    total_r, total_nxt;
  logic [SW-1:0]                    spages_r, spages_nxt;
  logic [AW-1:0]                    tmp_r, tmp_nxt;
  logic [AW-1:0]                    usable_base_r, usable_base_nxt;
  logic [FW-1:0]                    usable_frames_r, usable_frames_nxt;
  logic [FW-1:0]                    stack_depth_r, stack_depth_nxt;
  logic [FW-1:0]                    fill_cnt_r, fill_cnt_nxt;
  logic [AW-1:0]                    res_addr_r, res_addr_nxt;
  logic [1:0]                       res_status_r, res_status_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [AW-1:0]                    out_addr_r, out_addr_nxt;
  logic [1:0]                       out_status_r, out_status_nxt;

  logic [pfsa_pkg::SHIFT_W-1:0]     sh_eff;
  logic [AW-1:0]                    page_mask;
  pfsa_pkg::alu_ctl_t               alu_ctl;
  logic [AW-1:0]                    alu_a, alu_b, alu_res;
  logic                             alu_borrow;
  pfsa_pkg::ram_wr_t                ram_wr;
  logic                             ram_rd_en;
  logic [IW-1:0]                    ram_rd_addr, ram_rd_data;
  logic                             in_fire, out_free;
  logic                             idx_out_of_range;

  assign sh_eff    = pfsa_pkg::clamp_shift(page_shift_r);
  assign page_mask = ~({AW{1'b1}} << sh_eff);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == pfsa_pkg::ST_IDLE);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  // frame index from the free path against the usable frame count
  assign idx_out_of_range = (|alu_res[AW-1:FW]) || (alu_res[FW-1:0] >= usable_frames_r);

  pfsa_alu u_alu (
    .ctl    (alu_ctl),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  pfsa_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfsa_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            pfsa_pkg::REQ_INIT:  state_nxt = pfsa_pkg::ST_I_TOT;
            pfsa_pkg::REQ_ALLOC: state_nxt = pfsa_pkg::ST_A_POP;
            pfsa_pkg::REQ_FREE:  state_nxt = pfsa_pkg::ST_F_SUB;
            default:             state_nxt = pfsa_pkg::ST_RESP;
          endcase
        end
      end
      pfsa_pkg::ST_I_TOT:  state_nxt = pfsa_pkg::ST_I_ADD;
      pfsa_pkg::ST_I_ADD:  state_nxt = pfsa_pkg::ST_I_SPG;
      pfsa_pkg::ST_I_SPG:  state_nxt = pfsa_pkg::ST_I_SHL;
      pfsa_pkg::ST_I_SHL:  state_nxt = pfsa_pkg::ST_I_BASE;
      pfsa_pkg::ST_I_BASE: state_nxt = pfsa_pkg::ST_I_FRM;
      pfsa_pkg::ST_I_FRM:  state_nxt = pfsa_pkg::ST_I_FILL;
      pfsa_pkg::ST_I_FILL: begin
        if (fill_cnt_r == usable_frames_r) state_nxt = pfsa_pkg::ST_RESP;
      end
      pfsa_pkg::ST_A_POP: begin
        state_nxt = (stack_depth_r == '0) ? pfsa_pkg::ST_RESP : pfsa_pkg::ST_A_SHL;
      end
      pfsa_pkg::ST_A_SHL:  state_nxt = pfsa_pkg::ST_A_ADD;
      pfsa_pkg::ST_A_ADD:  state_nxt = pfsa_pkg::ST_RESP;
      pfsa_pkg::ST_F_SUB: begin
        state_nxt = alu_borrow ? pfsa_pkg::ST_RESP : pfsa_pkg::ST_F_SHR;
      end
      pfsa_pkg::ST_F_SHR:  state_nxt = pfsa_pkg::ST_RESP;
      pfsa_pkg::ST_RESP: begin
        if (out_free) state_nxt = pfsa_pkg::ST_IDLE;
      end
      default: state_nxt = pfsa_pkg::ST_IDLE;
    endcase
  end

  // datapath control and register next values
  always_comb begin
    req_type_nxt      = req_type_r;
    free_addr_nxt     = free_addr_r;
    total_nxt         = total_r;
    spages_nxt        = spages_r;
    tmp_nxt           = tmp_r;
    usable_base_nxt   = usable_base_r;
    usable_frames_nxt = usable_frames_r;
    stack_depth_nxt   = stack_depth_r;
    fill_cnt_nxt      = fill_cnt_r;
    res_addr_nxt      = res_addr_r;
    res_status_nxt    = res_status_r;
    out_valid_nxt     = out_valid_r;
    out_addr_nxt      = out_addr_r;
    out_status_nxt    = out_status_r;
    alu_ctl.op        = pfsa_pkg::ALU_ADD;
    alu_ctl.sh        = sh_eff;
    alu_a             = '0;
    alu_b             = '0;
    ram_wr.en         = 1'b0;
    ram_wr.addr       = stack_depth_r[IW-1:0];
    ram_wr.data       = '0;
    ram_rd_en         = 1'b0;
    ram_rd_addr       = '0;

    // receiver took the waiting result
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      pfsa_pkg::ST_IDLE: begin
        if (in_fire) begin
          req_type_nxt   = in_tuser;
          free_addr_nxt  = in_tdata;
          res_addr_nxt   = '0;
          res_status_nxt = pfsa_pkg::STATUS_OK;
        end
      end
      // frame count, saturated
      pfsa_pkg::ST_I_TOT: begin
        alu_ctl.op = pfsa_pkg::ALU_SHR;
        alu_a      = region_size_r;
        if ((|alu_res[AW-1:FW]) || (alu_res[FW-1:0] > MAX_FRM)) total_nxt = MAX_FRM;
        else total_nxt = alu_res[FW-1:0];
      end
      // four bytes per frame, rounded up to whole pages
      pfsa_pkg::ST_I_ADD: begin
        alu_ctl.op = pfsa_pkg::ALU_ADD;
        alu_a      = {{(AW-FW-2){1'b0}}, total_r, 2'b00};
        alu_b      = page_mask;
        tmp_nxt    = alu_res;
      end
      pfsa_pkg::ST_I_SPG: begin
        alu_ctl.op = pfsa_pkg::ALU_SHR;
        alu_a      = tmp_r;
        spages_nxt = alu_res[SW-1:0];
      end
      pfsa_pkg::ST_I_SHL: begin
        alu_ctl.op = pfsa_pkg::ALU_SHL;
        alu_a      = {{(AW-SW){1'b0}}, spages_r};
        tmp_nxt    = alu_res;
      end
      pfsa_pkg::ST_I_BASE: begin
        alu_ctl.op      = pfsa_pkg::ALU_ADD;
        alu_a           = region_base_r;
        alu_b           = tmp_r;
        usable_base_nxt = alu_res;
      end
      // frames left after the stack pages
      pfsa_pkg::ST_I_FRM: begin
        alu_ctl.op        = pfsa_pkg::ALU_SUB;
        alu_a             = {{(AW-FW){1'b0}}, total_r};
        alu_b             = {{(AW-SW){1'b0}}, spages_r};
        usable_frames_nxt = alu_borrow ? '0 : alu_res[FW-1:0];
        stack_depth_nxt   = alu_borrow ? '0 : alu_res[FW-1:0];
        fill_cnt_nxt      = '0;
      end
      // one stack entry per cycle
      pfsa_pkg::ST_I_FILL: begin
        if (fill_cnt_r != usable_frames_r) begin
          ram_wr.en    = 1'b1;
          ram_wr.addr  = fill_cnt_r[IW-1:0];
          ram_wr.data  = fill_cnt_r[IW-1:0];
          fill_cnt_nxt = fill_cnt_r + FW'(1);
        end
      end
      // pop: memory read issued here, data next cycle
      pfsa_pkg::ST_A_POP: begin
        if (stack_depth_r == '0) begin
          res_status_nxt = pfsa_pkg::STATUS_EMPTY;
        end else begin
          stack_depth_nxt = stack_depth_r - FW'(1);
          ram_rd_en       = 1'b1;
          ram_rd_addr     = stack_depth_nxt[IW-1:0];
        end
      end
      pfsa_pkg::ST_A_SHL: begin
        alu_ctl.op = pfsa_pkg::ALU_SHL;
        alu_a      = {{(AW-IW){1'b0}}, ram_rd_data};
        tmp_nxt    = alu_res;
      end
      pfsa_pkg::ST_A_ADD: begin
        alu_ctl.op   = pfsa_pkg::ALU_ADD;
        alu_a        = usable_base_r;
        alu_b        = tmp_r;
        res_addr_nxt = alu_res;
      end
      // free: offset from the usable base
      pfsa_pkg::ST_F_SUB: begin
        alu_ctl.op = pfsa_pkg::ALU_SUB;
        alu_a      = free_addr_r;
        alu_b      = usable_base_r;
        tmp_nxt    = alu_res;
        if (alu_borrow) res_status_nxt = pfsa_pkg::STATUS_RANGE;
      end
      // free: frame index, range and capacity checks, push
      pfsa_pkg::ST_F_SHR: begin
        alu_ctl.op = pfsa_pkg::ALU_SHR;
        alu_a      = tmp_r;
        if (idx_out_of_range) begin
          res_status_nxt = pfsa_pkg::STATUS_RANGE;
        end else if (stack_depth_r >= usable_frames_r) begin
          res_status_nxt = pfsa_pkg::STATUS_FULL;
        end else begin
          ram_wr.en       = 1'b1;
          ram_wr.addr     = stack_depth_r[IW-1:0];
          ram_wr.data     = alu_res[IW-1:0];
          stack_depth_nxt = stack_depth_r + FW'(1);
        end
      end
      // hand the result to the output register
      pfsa_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control and allocator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= pfsa_pkg::ST_IDLE;
      out_valid_r     <= 1'b0;
      usable_base_r   <= '0;
      usable_frames_r <= '0;
      stack_depth_r   <= '0;
      fill_cnt_r      <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      usable_base_r   <= usable_base_nxt;
      usable_frames_r <= usable_frames_nxt;
      stack_depth_r   <= stack_depth_nxt;
      fill_cnt_r      <= fill_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    free_addr_r  <= free_addr_nxt;
    total_r      <= total_nxt;
    spages_r     <= spages_nxt;
    tmp_r        <= tmp_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      region_size_r <= '0;
      page_shift_r  <= pfsa_pkg::SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfsa_pkg::CFG_REGION_BASE: region_base_r <= cfg_wdata;
        pfsa_pkg::CFG_REGION_SIZE: region_size_r <= cfg_wdata;
        pfsa_pkg::CFG_PAGE_SHIFT:  page_shift_r  <= cfg_wdata[pfsa_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // free count never exceeds the usable frame count
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_depth_r <= usable_frames_r)
    else $error("stack depth above usable frames");

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    usable_frames_r <= MAX_FRM)
    else $error("usable frames above maximum");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfsa_pkg::ST_I_FILL) |-> (fill_cnt_r <= usable_frames_r))
    else $error("fill counter ran past usable frames");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != pfsa_pkg::ST_IDLE))
    else $error("accepted transaction left sequencer idle");

  a_resp_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfsa_pkg::ST_RESP && out_valid_r && !out_tready)
      |=> (state_r == pfsa_pkg::ST_RESP && out_valid_r))
    else $error("result overwrote a waiting transaction");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the page frame stack allocator
`timescale 1ns / 100ps

module testbench;

  // request kind the block answers without acting on it
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         GAP_MAX     = 17;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
  } frame_req_t;

  typedef struct packed {
    logic [31:0] frame_addr;
    logic [1:0]  status;
  } frame_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [pfsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  page_frame_stack_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic [31:0]                  cfg_base = '0;
  logic [31:0]                  cfg_size = '0;
  logic [pfsa_pkg::SHIFT_W-1:0] cfg_shift = pfsa_pkg::SHIFT_RST;

  // allocator copy
  logic [pfsa_pkg::IDX_W-1:0] slot_mem [pfsa_pkg::MAX_FRAMES];
  logic [pfsa_pkg::FRM_W-1:0] free_depth = '0;
  logic [pfsa_pkg::FRM_W-1:0] usable_cnt = '0;
  logic [31:0]                frame_base = '0;

  frame_req_t   pending_reqs[$];
  frame_reply_t awaited_replies[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           rx_hold = 1'b0;
  bit           brisk = 1'b0;
  int           tx_gap = 0;
  int           rx_wait = 0;
  bit           tx_next_valid;
  bit           rx_next_ready;
  frame_req_t   tx_cur;

  // page shift as the block applies it
  function automatic int unsigned clamped_shift(input logic [pfsa_pkg::SHIFT_W-1:0] s);
    if (s < pfsa_pkg::SHIFT_MIN) return 32'(pfsa_pkg::SHIFT_MIN);
    if (s > pfsa_pkg::SHIFT_MAX) return 32'(pfsa_pkg::SHIFT_MAX);
    return 32'(s);
  endfunction

  // work out the reply to one accepted request and update the allocator copy
  function automatic void serve_request(input frame_req_t req);
    frame_reply_t rep;
    int unsigned  sh;
    int unsigned  total;
    int unsigned  spages;
    int unsigned  idx;
    rep.frame_addr = '0;
    rep.status     = pfsa_pkg::STATUS_OK;
    sh = clamped_shift(cfg_shift);
    case (req.kind)
      pfsa_pkg::REQ_INIT: begin
        total = cfg_size >> sh;
        if (total > pfsa_pkg::MAX_FRAMES) total = pfsa_pkg::MAX_FRAMES;
        spages = (4 * total + (32'd1 << sh) - 1) >> sh;
        frame_base = cfg_base + (spages << sh);
        usable_cnt = (total > spages) ? pfsa_pkg::FRM_W'(total - spages) : '0;
        for (int i = 0; i < int'(usable_cnt); i++)
          slot_mem[pfsa_pkg::IDX_W'(i)] = pfsa_pkg::IDX_W'(i);
        free_depth = usable_cnt;
      end
      pfsa_pkg::REQ_ALLOC: begin
        if (free_depth == '0) begin
          rep.status = pfsa_pkg::STATUS_EMPTY;
        end else begin
          free_depth = free_depth - pfsa_pkg::FRM_W'(1);
          rep.frame_addr = frame_base +
                           (32'(slot_mem[free_depth[pfsa_pkg::IDX_W-1:0]]) << sh);
        end
      end
      pfsa_pkg::REQ_FREE: begin
        if (req.addr < frame_base) begin
          rep.status = pfsa_pkg::STATUS_RANGE;
        end else begin
          idx = (req.addr - frame_base) >> sh;
          if (idx >= 32'(usable_cnt)) begin
            rep.status = pfsa_pkg::STATUS_RANGE;
          end else if (free_depth >= usable_cnt) begin
            rep.status = pfsa_pkg::STATUS_FULL;
          end else begin
            slot_mem[free_depth[pfsa_pkg::IDX_W-1:0]] = pfsa_pkg::IDX_W'(idx);
            free_depth = free_depth + pfsa_pkg::FRM_W'(1);
          end
        end
      end
      default: ;
    endcase
    awaited_replies.push_back(rep);
  endfunction

  // request driver
  always @(posedge clk) begin
    tx_next_valid = in_tvalid;
    if (!rst_n) begin
      tx_next_valid = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        serve_request(tx_cur);
        tx_next_valid = 1'b0;
        tx_gap = brisk ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!tx_next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_reqs.size() > 0) begin
          tx_cur = pending_reqs.pop_front();
          tx_next_valid = 1'b1;
          in_tdata <= tx_cur.addr;
          in_tuser <= tx_cur.kind;
        end
      end
    end
    in_tvalid <= tx_next_valid;
  end

  // reply monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t unexpected reply: expected none, got addr %h status %0d",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        if (out_tdata !== awaited_replies[0].frame_addr) begin
          $display("%0t frame_address mismatch: expected %h, got %h",
                   $time, awaited_replies[0].frame_addr, out_tdata);
          error_count++;
        end
        if (out_tuser !== awaited_replies[0].status) begin
          $display("%0t status mismatch: expected %0d, got %0d",
                   $time, awaited_replies[0].status, out_tuser);
          error_count++;
        end
        void'(awaited_replies.pop_front());
      end
      rx_wait = brisk ? 0 : $urandom_range(0, GAP_MAX);
    end
    if (rx_hold) begin
      rx_next_ready = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      rx_next_ready = 1'b0;
    end else begin
      rx_next_ready = 1'b1;
    end
    out_tready <= rx_next_ready;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [pfsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pfsa_pkg::CFG_REGION_BASE: cfg_base = val;
      pfsa_pkg::CFG_REGION_SIZE: cfg_size = val;
      pfsa_pkg::CFG_PAGE_SHIFT:  cfg_shift = val[pfsa_pkg::SHIFT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request has gone in and every reply has come back
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || awaited_replies.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic void push_req(input logic [1:0] kind, input logic [31:0] addr);
    frame_req_t r;
    r.kind = kind;
    r.addr = addr;
    pending_reqs.push_back(r);
  endfunction

  // mostly alloc and free of frames inside the region, some strays and inits
  function automatic void queue_random(input int n, input int alloc_pct);
    int unsigned sh;
    int unsigned pick;
    logic [31:0] page_mask;
    logic [31:0] addr;
    sh = clamped_shift(cfg_shift);
    page_mask = (32'd1 << sh) - 1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      addr = $urandom;
      if (pick < alloc_pct) begin
        push_req(pfsa_pkg::REQ_ALLOC, addr);
      end else if (pick < 86) begin
        if (usable_cnt > 0)
          addr = frame_base + ($urandom_range(0, usable_cnt - 1) << sh) + (addr & page_mask);
        push_req(pfsa_pkg::REQ_FREE, addr);
      end else if (pick < 90) begin
        if (frame_base > 0) addr = $urandom_range(0, frame_base - 1);
        push_req(pfsa_pkg::REQ_FREE, addr);
      end else if (pick < 94) begin
        // just past the last usable frame
        addr = frame_base + (32'(usable_cnt) << sh) + (addr & page_mask);
        push_req(pfsa_pkg::REQ_FREE, addr);
      end else if (pick < 96) begin
        push_req(pfsa_pkg::REQ_FREE, addr);
      end else if (pick < 98) begin
        push_req(REQ_UNUSED, addr);
      end else begin
        push_req(pfsa_pkg::REQ_INIT, addr);
      end
    end
  endfunction

  // one configuration, an init, then random traffic
  task automatic run_phase(input logic [31:0] base, input logic [31:0] size,
                           input logic [31:0] shv, input bit late_change,
                           input logic [31:0] late_shift, input int n,
                           input bit hold, input bit fast);
    write_reg(pfsa_pkg::CFG_REGION_BASE, base);
    write_reg(pfsa_pkg::CFG_REGION_SIZE, size);
    write_reg(pfsa_pkg::CFG_PAGE_SHIFT, shv);
    push_req(pfsa_pkg::REQ_INIT, $urandom);
    wait_quiet();
    if (late_change) write_reg(pfsa_pkg::CFG_PAGE_SHIFT, late_shift);
    @(negedge clk);
    brisk = fast;
    queue_random(n, (usable_cnt > 200) ? 60 : $urandom_range(35, 55));
    if (hold) begin
      // long receiver stall while requests keep coming
      @(negedge clk);
      rx_hold = 1'b1;
      repeat (300) @(negedge clk);
      rx_hold = 1'b0;
    end
    wait_quiet();
    brisk = 1'b0;
  endtask

  // stimulus
  initial begin
    logic [31:0] ub;
    int unsigned sh;
    int unsigned frames;
    logic [31:0] size;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // empty allocator straight out of reset
    push_req(pfsa_pkg::REQ_ALLOC, 32'h0);
    push_req(pfsa_pkg::REQ_FREE, 32'h0);
    push_req(pfsa_pkg::REQ_FREE, 32'hFFFF_FFFF);
    push_req(REQ_UNUSED, 32'hFFFF_FFFF);
    push_req(pfsa_pkg::REQ_INIT, 32'h0);
    wait_quiet();

    // 1 MiB region of 4 KiB pages
    write_reg(pfsa_pkg::CFG_REGION_BASE, 32'h1000_0000);
    write_reg(pfsa_pkg::CFG_REGION_SIZE, 32'h0010_0000);
    write_reg(pfsa_pkg::CFG_PAGE_SHIFT, 32'd12);
    push_req(pfsa_pkg::REQ_INIT, 32'h0);
    wait_quiet();
    ub = frame_base;
    push_req(pfsa_pkg::REQ_FREE, ub);
    push_req(pfsa_pkg::REQ_ALLOC, 32'h0);
    push_req(pfsa_pkg::REQ_ALLOC, 32'h0);
    push_req(pfsa_pkg::REQ_FREE, ub + (32'd5 << 12) + 32'hABC);
    push_req(pfsa_pkg::REQ_ALLOC, 32'h0);
    push_req(pfsa_pkg::REQ_FREE, cfg_base);
    push_req(pfsa_pkg::REQ_FREE, ub + (32'(usable_cnt) << 12));
    push_req(pfsa_pkg::REQ_FREE, ub + (32'd3 << 12));
    wait_quiet();

    // page shift raised after init
    write_reg(pfsa_pkg::CFG_PAGE_SHIFT, 32'd13);
    push_req(pfsa_pkg::REQ_ALLOC, 32'h0);
    push_req(pfsa_pkg::REQ_FREE, ub + (32'd2 << 13));
    wait_quiet();

    // stack pages swallow the whole region
    write_reg(pfsa_pkg::CFG_REGION_BASE, 32'h0);
    write_reg(pfsa_pkg::CFG_REGION_SIZE, 32'd64);
    write_reg(pfsa_pkg::CFG_PAGE_SHIFT, 32'd6);
    push_req(pfsa_pkg::REQ_INIT, 32'h0);
    push_req(pfsa_pkg::REQ_ALLOC, 32'h0);
    push_req(pfsa_pkg::REQ_FREE, 32'd64);
    wait_quiet();

    // random phases, extremes first
    run_phase($urandom, 32'hFFFF_FFFF, 32'd6, 1'b0, 32'd0, 140, 1'b0, 1'b0);
    run_phase($urandom, 32'hFFFF_FFFF, 32'd16, 1'b0, 32'd0, 140, 1'b0, 1'b1);
    run_phase(32'hFFFF_F800, 32'h0000_4000, 32'd8, 1'b0, 32'd0, 130, 1'b0, 1'b0);
    run_phase($urandom, 32'h0010_0000 | ($urandom & 32'h0003_FFFF),
              ($urandom & ~32'h1F) | 32'd31, 1'b0, 32'd0, 130, 1'b0, 1'b0);
    run_phase($urandom, 32'h0000_0A00 | ($urandom & 32'h3F), 32'd0,
              1'b0, 32'd0, 130, 1'b0, 1'b0);
    run_phase($urandom, 32'h0000_8000, 32'd10, 1'b1, 32'd12, 130, 1'b0, 1'b0);
    run_phase(32'h0, 32'h0, 32'd12, 1'b0, 32'd0, 40, 1'b0, 1'b0);
    run_phase($urandom, 32'h0000_0C00, 32'd6, 1'b0, 32'd0, 140, 1'b1, 1'b0);
    for (int p = 0; p < 8; p++) begin
      sh = $urandom_range(6, 16);
      frames = $urandom_range(2, 40);
      size = (frames << sh) | ($urandom & ((32'd1 << sh) - 1));
      run_phase($urandom, size, sh, p == 3, $urandom_range(6, 16), 112,
                1'b0, p[0]);
    end

    repeat (40) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
